>>> hw/rtl/ps2hfe_pkg.sv
// Shared types and constants for the PS/2 host frame engine.
package ps2hfe_pkg;

   localparam int FIFO_SLOTS_DEFAULT = 16;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [1:0] {
      FUNC_EDGE  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_START = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [8:0] {
      PH_RX_START  = 9'b000000001,
      PH_RX_DATA   = 9'b000000010,
      PH_RX_PARITY = 9'b000000100,
      PH_RX_STOP   = 9'b000001000,
      PH_TX_START  = 9'b000010000,
      PH_TX_DATA   = 9'b000100000,
      PH_TX_PARITY = 9'b001000000,
      PH_TX_STOP   = 9'b010000000,
      PH_TX_ACK    = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> hw/rtl/ps2hfe_fifo.sv
// Receive ring FIFO that keeps one slot free, with a registered read port.
module ps2hfe_fifo #(
   parameter int FIFO_SLOTS = ps2hfe_pkg::FIFO_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ps2hfe_pkg::fifo_ctl_type  ctl,
   input  logic [7:0]                wr_data,
   output ps2hfe_pkg::fifo_stat_type stat,
   output logic [7:0]                rd_data
);

   localparam int PTR_W = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_SLOTS - 1);

   logic [7:0]       mem [FIFO_SLOTS];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic [7:0]       rd_data_ff;

   assign wr_next = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;

   assign stat.full  = (wr_next == rd_ptr_ff);
   assign stat.empty = (wr_ptr_ff == rd_ptr_ff);

   assign wr_ptr_in = ctl.push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = ctl.pop  ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ps2_host_frame_engine.sv
// PS/2 host frame engine: receive/transmit frame sequencer with result register.
// One request is accepted per clock cycle while no result is held back by a low
// rsp_tready. Each request (clock falling edge with the sampled data bit, FIFO read,
// or transmit start) updates the frame state and the receive FIFO at its acceptance
// edge, and its result appears in the output register in the following cycle; a FIFO
// read returns its byte through the registered read port of the FIFO memory in that
// same cycle. While a result waits on rsp_tready, a new request is still taken in
// the cycle the result leaves. The FIFO holds FIFO_SLOTS-1 received bytes; its
// memory needs no clearing after reset.
module ps2_host_frame_engine #(
   parameter int FIFO_SLOTS = ps2hfe_pkg::FIFO_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] data_bit, [8:1] tx_byte, [15:9] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] line_driven, [1] line_level, [2] read_valid,
                                    // [10:3] read_byte, [11] byte_stored, [12] overflow,
                                    // [13] frame_error, [14] tx_done, [15] tx_acked
);

   ps2hfe_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]                shift_byte_ff, shift_byte_in;
   logic [3:0]                bit_count_ff, bit_count_in;
   logic                      got_parity_ff, got_parity_in;
   logic                      run_parity_ff, run_parity_in;
   logic                      drive_on_ff, drive_on_in;
   logic                      drive_val_ff, drive_val_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      read_valid_ff, read_valid_in;
   logic                      byte_stored_ff, byte_stored_in;
   logic                      overflow_ff, overflow_in;
   logic                      frame_error_ff, frame_error_in;
   logic                      tx_done_ff, tx_done_in;
   logic                      tx_acked_ff, tx_acked_in;

   logic                      req_fire;
   ps2hfe_pkg::func_type      func;
   logic                      data_bit;
   logic [7:0]                tx_byte;
   logic                      tx_bit;
   ps2hfe_pkg::fifo_ctl_type  fifo_ctl;
   ps2hfe_pkg::fifo_stat_type fifo_stat;
   logic [7:0]                fifo_rd_data;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign func       = ps2hfe_pkg::func_type'(req_tuser);
   assign data_bit   = req_tdata[0];
   assign tx_byte    = req_tdata[8:1];
   assign tx_bit     = shift_byte_ff[bit_count_ff[2:0]];

   ps2hfe_fifo #(
      .FIFO_SLOTS(FIFO_SLOTS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .wr_data (shift_byte_ff),
      .stat    (fifo_stat),
      .rd_data (fifo_rd_data)
   );

   always_comb begin
      phase_in       = phase_ff;
      shift_byte_in  = shift_byte_ff;
      bit_count_in   = bit_count_ff;
      got_parity_in  = got_parity_ff;
      run_parity_in  = run_parity_ff;
      drive_on_in    = drive_on_ff;
      drive_val_in   = drive_val_ff;
      fifo_ctl       = '0;
      read_valid_in  = 1'b0;
      byte_stored_in = 1'b0;
      overflow_in    = 1'b0;
      frame_error_in = 1'b0;
      tx_done_in     = 1'b0;
      tx_acked_in    = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         case (func)
            ps2hfe_pkg::FUNC_EDGE: begin
               case (phase_ff)
                  ps2hfe_pkg::PH_TX_START: begin
                     bit_count_in  = '0;
                     run_parity_in = 1'b1;
                     phase_in      = ps2hfe_pkg::PH_TX_DATA;
                  end
                  ps2hfe_pkg::PH_TX_DATA: begin
                     drive_on_in   = 1'b1;
                     drive_val_in  = tx_bit;
                     run_parity_in = run_parity_ff ^ tx_bit;
                     bit_count_in  = bit_count_ff + 1'b1;
                     if (bit_count_in >= ps2hfe_pkg::BITS_PER_BYTE) begin
                        phase_in = ps2hfe_pkg::PH_TX_PARITY;
                     end
                  end
                  ps2hfe_pkg::PH_TX_PARITY: begin
                     drive_on_in  = 1'b1;
                     drive_val_in = run_parity_ff;
                     phase_in     = ps2hfe_pkg::PH_TX_STOP;
                  end
                  ps2hfe_pkg::PH_TX_STOP: begin
                     drive_on_in  = 1'b0;
                     drive_val_in = 1'b0;
                     phase_in     = ps2hfe_pkg::PH_TX_ACK;
                  end
                  ps2hfe_pkg::PH_TX_ACK: begin
                     drive_on_in  = 1'b0;
                     drive_val_in = 1'b0;
                     tx_done_in   = 1'b1;
                     tx_acked_in  = !data_bit;
                     phase_in     = ps2hfe_pkg::PH_RX_START;
                  end
                  ps2hfe_pkg::PH_RX_DATA: begin
                     drive_on_in   = 1'b0;
                     drive_val_in  = 1'b0;
                     shift_byte_in = shift_byte_ff | (8'(data_bit) << bit_count_ff[2:0]);
                     run_parity_in = run_parity_ff ^ data_bit;
                     bit_count_in  = bit_count_ff + 1'b1;
                     if (bit_count_in >= ps2hfe_pkg::BITS_PER_BYTE) begin
                        phase_in = ps2hfe_pkg::PH_RX_PARITY;
                     end
                  end
                  ps2hfe_pkg::PH_RX_PARITY: begin
                     drive_on_in   = 1'b0;
                     drive_val_in  = 1'b0;
                     got_parity_in = data_bit;
                     phase_in      = ps2hfe_pkg::PH_RX_STOP;
                  end
                  ps2hfe_pkg::PH_RX_STOP: begin
                     drive_on_in  = 1'b0;
                     drive_val_in = 1'b0;
                     phase_in     = ps2hfe_pkg::PH_RX_START;
                     if (data_bit && (got_parity_ff == run_parity_ff)) begin
                        // drop the byte when the ring has no free slot
                        if (fifo_stat.full) begin
                           overflow_in = 1'b1;
                        end else begin
                           fifo_ctl.push  = 1'b1;
                           byte_stored_in = 1'b1;
                        end
                     end else begin
                        frame_error_in = 1'b1;
                     end
                  end
                  default: begin
                     // idle: a low start bit opens a frame
                     drive_on_in  = 1'b0;
                     drive_val_in = 1'b0;
                     phase_in     = ps2hfe_pkg::PH_RX_START;
                     if (!data_bit) begin
                        shift_byte_in = '0;
                        bit_count_in  = '0;
                        run_parity_in = 1'b1;
                        phase_in      = ps2hfe_pkg::PH_RX_DATA;
                     end
                  end
               endcase
            end
            ps2hfe_pkg::FUNC_READ: begin
               if (!fifo_stat.empty) begin
                  fifo_ctl.pop  = 1'b1;
                  read_valid_in = 1'b1;
               end
            end
            ps2hfe_pkg::FUNC_START: begin
               // abandon any frame in progress and drive the start bit
               shift_byte_in = tx_byte;
               drive_on_in   = 1'b1;
               drive_val_in  = 1'b0;
               phase_in      = ps2hfe_pkg::PH_TX_START;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ps2hfe_pkg::PH_RX_START;
         shift_byte_ff <= '0;
         bit_count_ff  <= '0;
         got_parity_ff <= 1'b0;
         run_parity_ff <= 1'b1;
         drive_on_ff   <= 1'b0;
         drive_val_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         shift_byte_ff <= shift_byte_in;
         bit_count_ff  <= bit_count_in;
         got_parity_ff <= got_parity_in;
         run_parity_ff <= run_parity_in;
         drive_on_ff   <= drive_on_in;
         drive_val_ff  <= drive_val_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload; the line outputs follow the drive state after the request
   logic line_driven_ff, line_level_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_driven_ff <= drive_on_in;
         line_level_ff  <= drive_on_in && drive_val_in;
         read_valid_ff  <= read_valid_in;
         byte_stored_ff <= byte_stored_in;
         overflow_ff    <= overflow_in;
         frame_error_ff <= frame_error_in;
         tx_done_ff     <= tx_done_in;
         tx_acked_ff    <= tx_acked_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {tx_acked_ff, tx_done_ff, frame_error_ff, overflow_ff,
                        byte_stored_ff, (read_valid_ff ? fifo_rd_data : 8'h00),
                        read_valid_ff, line_level_ff, line_driven_ff};

endmodule

>>> hw/rtl/ps2hfe_checker.sv
// Port-level checks for the PS/2 host frame engine, bound to the top level.
module ps2hfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // an acknowledge flag only comes with the end of a transmit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[14])
      else $error("tx_acked without tx_done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:3] != 8'h00) |-> rsp_tdata[2])
      else $error("read_byte nonzero without read_valid");

   // events of one request are mutually exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({rsp_tdata[2], rsp_tdata[11], rsp_tdata[12],
                                 rsp_tdata[13], rsp_tdata[14]}) <= 1)
      else $error("more than one event flag in one result");

   // a transmit start drives the start bit low in its result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ps2hfe_pkg::FUNC_START)
      |=> rsp_tvalid && rsp_tdata[0] && !rsp_tdata[1])
      else $error("transmit start did not drive the line low");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind ps2_host_frame_engine ps2hfe_checker u_ps2hfe_checker (.*);

>>> test/tb_ps2_host_frame_engine.sv
// Self-checking testbench for the PS/2 host frame engine with bursty traffic and stalls.
module tb_ps2_host_frame_engine;

   localparam int FIFO_SLOTS = ps2hfe_pkg::FIFO_SLOTS_DEFAULT;
   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic       tx_acked;
      logic       tx_done;
      logic       frame_error;
      logic       overflow;
      logic       byte_stored;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       line_level;
      logic       line_driven;
   } ps2_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [0] data_bit, [8:1] tx_byte, [15:9] zero
   logic [1:0]  req_tuser = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] line_driven, [1] line_level, [2] read_valid,
                                  // [10:3] read_byte, [11] byte_stored, [12] overflow,
                                  // [13] frame_error, [14] tx_done, [15] tx_acked

   // frame engine shadow state
   ps2hfe_pkg::phase_type sh_phase;
   logic [7:0] sh_shift;
   logic [3:0] sh_count;
   logic       sh_got_par;
   logic       sh_run_par;
   logic [7:0] sh_fifo[FIFO_SLOTS];
   int         sh_wr;
   int         sh_rd;
   logic       sh_drive_on;
   logic       sh_drive_val;

   ps2_result_type expected_results[$];
   int          fail_count = 0;
   int          requests_sent = 0;
   int          idle_cycles = 0;

   // sender and receiver pacing
   bit          req_live = 1'b0;
   int          burst_left = 0;
   int          gap_max = 0;
   int          ready_mode = 0;
   int          stall_left = 0;

   ps2_host_frame_engine #(.FIFO_SLOTS(FIFO_SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic int ring_advance(input int idx);
      return (idx + 1 >= FIFO_SLOTS) ? 0 : idx + 1;
   endfunction

   function automatic void release_line();
      sh_drive_on = 1'b0;
      sh_drive_val = 1'b0;
   endfunction

   function automatic ps2_result_type predict_frame_step(input ps2hfe_pkg::func_type fn,
                                                         input logic dbit,
                                                         input logic [7:0] tx_val);
      ps2_result_type r;
      logic        b;
      r = '0;
      case (fn)
         ps2hfe_pkg::FUNC_EDGE: begin
            case (sh_phase)
               ps2hfe_pkg::PH_RX_DATA: begin
                  release_line();
                  sh_shift = sh_shift | (8'(dbit) << sh_count[2:0]);
                  sh_count = sh_count + 4'd1;
                  sh_run_par = sh_run_par ^ dbit;
                  if (sh_count >= ps2hfe_pkg::BITS_PER_BYTE) begin
                     sh_phase = ps2hfe_pkg::PH_RX_PARITY;
                  end
               end
               ps2hfe_pkg::PH_RX_PARITY: begin
                  release_line();
                  sh_got_par = dbit;
                  sh_phase = ps2hfe_pkg::PH_RX_STOP;
               end
               ps2hfe_pkg::PH_RX_STOP: begin
                  release_line();
                  if (dbit && sh_got_par == sh_run_par) begin
                     if (ring_advance(sh_wr) == sh_rd) begin
                        r.overflow = 1'b1;
                     end else begin
                        sh_fifo[sh_wr] = sh_shift;
                        sh_wr = ring_advance(sh_wr);
                        r.byte_stored = 1'b1;
                     end
                  end else begin
                     r.frame_error = 1'b1;
                  end
                  sh_phase = ps2hfe_pkg::PH_RX_START;
               end
               ps2hfe_pkg::PH_TX_START: begin
                  sh_count = '0;
                  sh_run_par = 1'b1;
                  sh_phase = ps2hfe_pkg::PH_TX_DATA;
               end
               ps2hfe_pkg::PH_TX_DATA: begin
                  b = sh_shift[sh_count[2:0]];
                  sh_drive_on = 1'b1;
                  sh_drive_val = b;
                  sh_run_par = sh_run_par ^ b;
                  sh_count = sh_count + 4'd1;
                  if (sh_count >= ps2hfe_pkg::BITS_PER_BYTE) begin
                     sh_phase = ps2hfe_pkg::PH_TX_PARITY;
                  end
               end
               ps2hfe_pkg::PH_TX_PARITY: begin
                  sh_drive_on = 1'b1;
                  sh_drive_val = sh_run_par;
                  sh_phase = ps2hfe_pkg::PH_TX_STOP;
               end
               ps2hfe_pkg::PH_TX_STOP: begin
                  release_line();
                  sh_phase = ps2hfe_pkg::PH_TX_ACK;
               end
               ps2hfe_pkg::PH_TX_ACK: begin
                  release_line();
                  r.tx_done = 1'b1;
                  r.tx_acked = ~dbit;
                  sh_phase = ps2hfe_pkg::PH_RX_START;
               end
               default: begin
                  // a high level while idle is no start bit
                  release_line();
                  sh_phase = ps2hfe_pkg::PH_RX_START;
                  if (!dbit) begin
                     sh_shift = '0;
                     sh_count = '0;
                     sh_run_par = 1'b1;
                     sh_phase = ps2hfe_pkg::PH_RX_DATA;
                  end
               end
            endcase
         end
         ps2hfe_pkg::FUNC_READ: begin
            if (sh_wr != sh_rd) begin
               r.read_valid = 1'b1;
               r.read_byte = sh_fifo[sh_rd];
               sh_rd = ring_advance(sh_rd);
            end
         end
         ps2hfe_pkg::FUNC_START: begin
            // abandon any frame in progress and drive the start bit
            sh_shift = tx_val;
            sh_drive_on = 1'b1;
            sh_drive_val = 1'b0;
            sh_phase = ps2hfe_pkg::PH_TX_START;
         end
         default: ;
      endcase
      r.line_driven = sh_drive_on;
      r.line_level = sh_drive_on & sh_drive_val;
      return r;
   endfunction

   task automatic lower_valid();
      if (req_live) begin
         req_tvalid <= 1'b0;
         req_live = 1'b0;
      end
   endtask

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (gap_max > 0) begin
            lower_valid();
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic send_request(input ps2hfe_pkg::func_type fn, input logic dbit,
                               input logic [7:0] tx_val);
      if (!req_live) begin
         req_tvalid <= 1'b1;
         req_live = 1'b1;
      end
      req_tuser <= fn;
      req_tdata <= {7'b0, tx_val, dbit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_frame_step(fn, dbit, tx_val));
      requests_sent++;
      pace_sender();
   endtask

   task automatic wait_drained();
      lower_valid();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic send_rx_frame(input logic [7:0] data, input logic bad_par,
                                input logic bad_stop);
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b0, 8'($urandom));
      for (int i = 0; i < 8; i++) send_request(ps2hfe_pkg::FUNC_EDGE, data[i], 8'($urandom));
      send_request(ps2hfe_pkg::FUNC_EDGE, (~^data) ^ bad_par, 8'($urandom));
      send_request(ps2hfe_pkg::FUNC_EDGE, ~bad_stop, 8'($urandom));
   endtask

   // start a transmit, then clock it; edges for the start, data, parity and stop bits run it through the acknowledge
   task automatic send_tx_sequence(input logic [7:0] data, input int edges,
                                   input logic ack_low);
      send_request(ps2hfe_pkg::FUNC_START, 1'($urandom), data);
      for (int i = 0; i < edges; i++) begin
         if (i == 11) send_request(ps2hfe_pkg::FUNC_EDGE, ~ack_low, 8'($urandom));
         else send_request(ps2hfe_pkg::FUNC_EDGE, 1'($urandom), 8'($urandom));
      end
   endtask

   task automatic send_reads(input int n);
      for (int i = 0; i < n; i++) begin
         send_request(ps2hfe_pkg::FUNC_READ, 1'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_idle_cases();
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b1, 8'h00);
      send_request(ps2hfe_pkg::FUNC_NONE, 1'b1, 8'hFF);
      send_reads(1);
   endtask

   task automatic test_abandon_and_transmit();
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b0, 8'h00);
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b1, 8'h00);
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b0, 8'h00);
      send_request(ps2hfe_pkg::FUNC_EDGE, 1'b1, 8'h00);
      send_tx_sequence(8'hFF, 12, 1'b1);
      send_tx_sequence(8'h00, 12, 1'b0);
   endtask

   task automatic test_fifo_overflow();
      for (int i = 0; i < FIFO_SLOTS; i++) send_rx_frame(pick_byte(), 1'b0, 1'b0);
      send_rx_frame(8'hA5, 1'b1, 1'b0);
      send_rx_frame(8'h5A, 1'b0, 1'b1);
      send_reads(FIFO_SLOTS + 1);
   endtask

   task automatic test_random_traffic(input int n_items);
      int target;
      int kind;
      target = requests_sent + n_items;
      while (requests_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            send_rx_frame(pick_byte(), 1'b0, 1'b0);
         end else if (kind < 50) begin
            case ($urandom_range(0, 2))
               0: send_rx_frame(pick_byte(), 1'b1, 1'b0);
               1: send_rx_frame(pick_byte(), 1'b0, 1'b1);
               default: begin
                  // cut the frame short and let the next request pick it up
                  send_request(ps2hfe_pkg::FUNC_EDGE, 1'b0, 8'($urandom));
                  repeat ($urandom_range(0, 9)) begin
                     send_request(ps2hfe_pkg::FUNC_EDGE, 1'($urandom), 8'($urandom));
                  end
               end
            endcase
         end else if (kind < 70) begin
            if ($urandom_range(0, 3) != 0) send_tx_sequence(pick_byte(), 12, 1'($urandom));
            else send_tx_sequence(pick_byte(), $urandom_range(0, 11), 1'($urandom));
         end else if (kind < 93) begin
            send_reads($urandom_range(1, 4));
         end else begin
            send_request(ps2hfe_pkg::func_type'($urandom_range(0, 3)), 1'($urandom),
                         8'($urandom));
         end
      end
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // receiver stalls in short random runs, denser in mode 2
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < (ready_mode == 1 ? 25 : 50)) begin
         stall_left = $urandom_range(0, ready_mode == 1 ? 2 : 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      ps2_result_type act;
      ps2_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = rsp_tdata;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %04h", $time, rsp_tdata);
            fail_count++;
         end else begin
            exp = expected_results.pop_front();
            check_field("line_driven", exp.line_driven, act.line_driven);
            check_field("line_level", exp.line_level, act.line_level);
            check_field("read_valid", exp.read_valid, act.read_valid);
            check_field("read_byte", exp.read_byte, act.read_byte);
            check_field("byte_stored", exp.byte_stored, act.byte_stored);
            check_field("overflow", exp.overflow, act.overflow);
            check_field("frame_error", exp.frame_error, act.frame_error);
            check_field("tx_done", exp.tx_done, act.tx_done);
            check_field("tx_acked", exp.tx_acked, act.tx_acked);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** ps2_host_frame_engine: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      sh_phase = ps2hfe_pkg::PH_RX_START;
      sh_shift = '0;
      sh_count = '0;
      sh_got_par = 1'b0;
      sh_run_par = 1'b1;
      sh_wr = 0;
      sh_rd = 0;
      sh_drive_on = 1'b0;
      sh_drive_val = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_max = 0;
      ready_mode = 0;
      test_idle_cases();
      test_abandon_and_transmit();
      wait_drained();

      gap_max = 4;
      ready_mode = 1;
      test_fifo_overflow();
      wait_drained();

      gap_max = 0;
      ready_mode = 0;
      test_random_traffic(60);
      wait_drained();
      gap_max = 6;
      ready_mode = 1;
      test_random_traffic(60);
      wait_drained();
      gap_max = 3;
      ready_mode = 2;
      test_random_traffic(60);
      wait_drained();
      gap_max = 6;
      ready_mode = 2;
      test_random_traffic(60);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** ps2_host_frame_engine: PASSED **");
      end else begin
         $display("** ps2_host_frame_engine: FAILED **");
      end
      $finish;
   end

endmodule

>>> ps2_host_frame_engine.f
hw/rtl/ps2hfe_pkg.sv
hw/rtl/ps2hfe_fifo.sv
hw/rtl/ps2_host_frame_engine.sv
hw/rtl/ps2hfe_checker.sv
test/tb_ps2_host_frame_engine.sv
